/* rtl/oqme_pkg.sv */
// shared types and constants of the ordered queue with match extract
// no dependencies
package oqme_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_POP     = 2'd1,
        CMD_EXTRACT = 2'd2,
        CMD_UNKNOWN = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ENTRY   = 3'd0,
        ST_ADDED   = 3'd1,
        ST_NONE    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_CLOSED  = 3'd4,
        ST_FULL    = 3'd5,
        ST_INVALID = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic    load;
        logic    push_stat;
        status_t stat;
        logic    append;
        logic    pop;
        logic    start_scan;
        logic    scan_en;
    } dp_ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic closed;
        logic empty;
        logic full;
        logic dir_zero;
        logic scan_done;
        logic count_zero;
        logic can_push;
    } dp_sts_t;

endpackage

/* rtl/oqme_ctrl.sv */
// command sequencer of the ordered queue with match extract
// depends on oqme_pkg
module oqme_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  oqme_pkg::dp_sts_t sts,
    output oqme_pkg::dp_ctl_t ctl
);
    import oqme_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.cmd == CMD_EXTRACT && !sts.dir_zero && !sts.closed && !sts.empty)
                begin
                    state_next = S_SCAN;
                end
                else if (sts.can_push)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done && (!sts.count_zero || sts.can_push))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.stat = ST_INVALID;
        in_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.load = in_valid;
            end
            S_EXEC:
            begin
                case (sts.cmd)
                    CMD_APPEND:
                    begin
                        ctl.push_stat = sts.can_push;
                        ctl.stat = sts.full ? ST_FULL : ST_ADDED;
                        ctl.append = sts.can_push && !sts.full;
                    end
                    CMD_POP:
                    begin
                        if (sts.closed)
                        begin
                            ctl.push_stat = sts.can_push;
                            ctl.stat = ST_CLOSED;
                        end
                        else if (sts.empty)
                        begin
                            ctl.push_stat = sts.can_push;
                            ctl.stat = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.pop = sts.can_push;
                        end
                    end
                    CMD_EXTRACT:
                    begin
                        if (sts.dir_zero)
                        begin
                            ctl.push_stat = sts.can_push;
                            ctl.stat = ST_INVALID;
                        end
                        else if (sts.closed)
                        begin
                            ctl.push_stat = sts.can_push;
                            ctl.stat = ST_CLOSED;
                        end
                        else if (sts.empty)
                        begin
                            ctl.push_stat = sts.can_push;
                            ctl.stat = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.start_scan = 1'b1;
                        end
                    end
                    default:
                    begin
                        ctl.push_stat = sts.can_push;
                        ctl.stat = ST_INVALID;
                    end
                endcase
            end
            S_SCAN:
            begin
                ctl.scan_en = 1'b1;
                if (sts.scan_done && sts.count_zero)
                begin
                    ctl.push_stat = sts.can_push;
                    ctl.stat = ST_NONE;
                end
            end
            default: ctl = '0;
        endcase
    end

endmodule

/* rtl/oqme_dp.sv */
// datapath: queue slots, scan counter, match logic and output register
// depends on oqme_pkg
module oqme_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  oqme_pkg::dp_ctl_t         ctl,
    output oqme_pkg::dp_sts_t         sts,
    input  logic                      closed,
    input  logic [1:0]                cmd,
    input  logic [31:0]               person_id,
    input  logic [7:0]                src_floor,
    input  logic [7:0]                dst_floor,
    input  logic [31:0]               arrive_tick,
    input  logic [7:0]                match_floor,
    input  logic signed [1:0]         direction,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                status,
    output logic [31:0]               person_id_res,
    output logic [7:0]                src_floor_res,
    output logic [7:0]                dst_floor_res,
    output logic [31:0]               arrive_tick_res,
    output logic [6:0]                pick_count,
    output logic                      last
);
    import oqme_pkg::*;

    logic [31:0] id_reg   [QUEUE_DEPTH];
    logic [7:0]  src_reg  [QUEUE_DEPTH];
    logic [7:0]  dst_reg  [QUEUE_DEPTH];
    logic [31:0] tim_reg  [QUEUE_DEPTH];
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] scan_reg;
    logic [CNT_W-1:0] count_reg;

    cmd_t        cmd_reg;
    logic [31:0] in_id_reg;
    logic [7:0]  in_src_reg;
    logic [7:0]  in_dst_reg;
    logic [31:0] in_tim_reg;
    logic [7:0]  floor_reg;
    logic [1:0]  dir_reg;

    logic        out_valid_reg;
    status_t     status_reg;
    logic [31:0] id_out_reg;
    logic [7:0]  src_out_reg;
    logic [7:0]  dst_out_reg;
    logic [31:0] tim_out_reg;
    logic [6:0]  pick_reg;
    logic        last_reg;

    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] lower;
    logic [CNT_W-1:0]       scan_m1;
    logic [IDX_W-1:0]       scan_idx;
    logic [IDX_W-1:0]       rd_idx;
    logic                   can_push;
    logic                   scan_done;
    logic                   hit;
    logic                   emit_hit;
    logic                   remove_en;
    logic                   up;

    assign can_push  = !out_valid_reg || !out_stall;
    assign scan_done = (scan_reg == '0);
    assign scan_m1   = scan_reg - 1'b1;
    assign scan_idx  = scan_m1[IDX_W-1:0];
    assign up        = (dir_reg == 2'b01);

    // match over live slots; lower marks slots still ahead of the scan
    always_comb
    begin
        for (int j = 0; j < QUEUE_DEPTH; j++)
        begin
            match[j] = (CNT_W'(j) < occ_reg) && (src_reg[j] == floor_reg) &&
                       (up ? (dst_reg[j] > src_reg[j]) : (dst_reg[j] < src_reg[j]));
            lower[j] = (CNT_W'(j) < scan_m1);
        end
    end

    assign hit       = match[scan_idx];
    assign emit_hit  = ctl.scan_en && !scan_done && hit && can_push;
    assign remove_en = ctl.pop || emit_hit;
    assign rd_idx    = ctl.pop ? '0 : scan_idx;

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.closed     = closed;
        sts.empty      = (occ_reg == '0);
        sts.full       = (occ_reg == CNT_W'(QUEUE_DEPTH));
        sts.dir_zero   = (dir_reg == 2'b00);
        sts.scan_done  = scan_done;
        sts.count_zero = (count_reg == '0);
        sts.can_push   = can_push;
    end

    // slot storage: append at tail, removal closes ranks above the slot
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QUEUE_DEPTH; j++)
        begin
            if (remove_en && (IDX_W'(j) >= rd_idx) && (j < QUEUE_DEPTH - 1))
            begin
                id_reg[j]  <= id_reg[(j + 1) % QUEUE_DEPTH];
                src_reg[j] <= src_reg[(j + 1) % QUEUE_DEPTH];
                dst_reg[j] <= dst_reg[(j + 1) % QUEUE_DEPTH];
                tim_reg[j] <= tim_reg[(j + 1) % QUEUE_DEPTH];
            end
            else if (ctl.append && (occ_reg == CNT_W'(j)))
            begin
                id_reg[j]  <= in_id_reg;
                src_reg[j] <= in_src_reg;
                dst_reg[j] <= in_dst_reg;
                tim_reg[j] <= in_tim_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            scan_reg  <= '0;
            count_reg <= '0;
            cmd_reg   <= CMD_APPEND;
        end
        else
        begin
            if (ctl.load)
            begin
                cmd_reg <= cmd_t'(cmd);
            end
            if (ctl.append)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
            else if (remove_en)
            begin
                occ_reg <= occ_reg - 1'b1;
            end
            if (ctl.start_scan)
            begin
                scan_reg  <= occ_reg;
                count_reg <= '0;
            end
            else if (ctl.scan_en && !scan_done && (!hit || can_push))
            begin
                scan_reg <= scan_m1;
                if (hit)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            in_id_reg  <= person_id;
            in_src_reg <= src_floor;
            in_dst_reg <= dst_floor;
            in_tim_reg <= arrive_tick;
            floor_reg  <= match_floor;
            dir_reg    <= direction;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.push_stat || remove_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push_stat)
        begin
            status_reg  <= ctl.stat;
            id_out_reg  <= '0;
            src_out_reg <= '0;
            dst_out_reg <= '0;
            tim_out_reg <= '0;
            pick_reg    <= '0;
            last_reg    <= 1'b1;
        end
        else if (remove_en)
        begin
            status_reg  <= ST_ENTRY;
            id_out_reg  <= id_reg[rd_idx];
            src_out_reg <= src_reg[rd_idx];
            dst_out_reg <= dst_reg[rd_idx];
            tim_out_reg <= tim_reg[rd_idx];
            pick_reg    <= ctl.pop ? 7'd1 : 7'(count_reg + 1'b1);
            last_reg    <= ctl.pop ? 1'b1 : !(|(match & lower));
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign person_id_res   = id_out_reg;
    assign src_floor_res   = src_out_reg;
    assign dst_floor_res   = dst_out_reg;
    assign arrive_tick_res = tim_out_reg;
    assign pick_count      = pick_reg;
    assign last            = last_reg;

endmodule

/* rtl/ordered_queue_with_match_extract_top.sv */
// top level of the ordered queue with match extract: apb register, sequencer, datapath
// depends on oqme_pkg, oqme_ctrl, oqme_dp
//
// usage: an input item (cmd plus fields) is taken when in_valid is high and in_stall low.
// in_stall is high while a command is being worked on; one command at a time.
// append, pop and status-only answers land in the output register from the exec state, once
// the register can take them; the sequencer then returns to idle for the next item.
// an extract walks the queue from tail to head, one slot per cycle while no match waits on
// the output register, then finishes from the scan state: a none-matched item lands once the
// walk is done, and the next input item can be taken once the sequencer is back in idle.
// matches come out newest first, one item each, pick_count counting up, last on the
// final one; no match gives one none-matched item.
// results sit in an output register: out_valid holds with the payload fixed while
// out_stall is high, and the walk pauses on a match until the register frees.
// a new input item is taken while the last result still waits.
// reset empties the queue and clears the closed register; slot contents are not cleared.
// the closed register sits at address 0 of the apb port; write it only while idle, the block does not enforce this.
module ordered_queue_with_match_extract_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [31:0]        person_id,
    input  logic [7:0]         src_floor,
    input  logic [7:0]         dst_floor,
    input  logic [31:0]        arrive_tick,
    input  logic [7:0]         match_floor,
    input  logic signed [1:0]  direction,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [31:0]        person_id_res,
    output logic [7:0]         src_floor_res,
    output logic [7:0]         dst_floor_res,
    output logic [31:0]        arrive_tick_res,
    output logic [6:0]         pick_count,
    output logic               last
);
    import oqme_pkg::*;

    logic    closed_reg;
    logic    addr_hit;
    dp_ctl_t ctl;
    dp_sts_t sts;

    assign pready   = 1'b1;
    // single register at byte address 0
    assign addr_hit = (paddr == 2'd0);
    assign prdata   = {31'd0, closed_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && addr_hit)
        begin
            closed_reg <= pwdata[0];
        end
    end

    oqme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    oqme_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .closed          (closed_reg),
        .cmd             (cmd),
        .person_id       (person_id),
        .src_floor       (src_floor),
        .dst_floor       (dst_floor),
        .arrive_tick     (arrive_tick),
        .match_floor     (match_floor),
        .direction       (direction),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .person_id_res   (person_id_res),
        .src_floor_res   (src_floor_res),
        .dst_floor_res   (dst_floor_res),
        .arrive_tick_res (arrive_tick_res),
        .pick_count      (pick_count),
        .last            (last)
    );

endmodule

/* test/tb_top.sv */
// self-checking testbench of ordered_queue_with_match_extract_top: directed table, then random
// depends on oqme_pkg and the rtl of ordered_queue_with_match_extract_top
`timescale 1ns / 100ps

module tb_top;
    import oqme_pkg::*;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] id;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [31:0] tick;
        logic [7:0]  floor;
        logic [1:0]  dir;
    } req_t;

    typedef struct {
        logic [2:0]  st;
        logic [31:0] id;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [31:0] tick;
        logic [6:0]  cnt;
        logic        fin;
    } answer_t;

    // directed row: request plus optional typed answer
    typedef struct {
        req_t        rq;
        logic        typed;
        logic [2:0]  st;
    } row_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_stall;
    logic [1:0] cmd;
    logic [31:0] person_id, arrive_tick;
    logic [7:0] src_floor, dst_floor, match_floor;
    logic signed [1:0] direction;
    logic out_valid, out_stall;
    logic [2:0] status;
    logic [31:0] person_id_res, arrive_tick_res;
    logic [7:0] src_floor_res, dst_floor_res;
    logic [6:0] pick_count;
    logic last;

    ordered_queue_with_match_extract_top u_dut (.*);

    // mirror of the queue
    logic [31:0] q_id [QUEUE_DEPTH];
    logic [7:0]  q_src [QUEUE_DEPTH];
    logic [7:0]  q_dst [QUEUE_DEPTH];
    logic [31:0] q_tick [QUEUE_DEPTH];
    int          q_len;
    logic        is_closed;

    answer_t pending_answers[$];
    int      n_errors;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("ordered_queue_with_match_extract_top regression: fail");
        $finish;
    end

    function automatic answer_t status_answer(logic [2:0] s);
        answer_t a;
        a = '{st: s, id: '0, src: '0, dst: '0, tick: '0, cnt: '0, fin: 1'b1};
        return a;
    endfunction

    function automatic void drop_slot(int k);
        for (int i = k; i + 1 < q_len; i++)
        begin
            q_id[i] = q_id[i + 1];
            q_src[i] = q_src[i + 1];
            q_dst[i] = q_dst[i + 1];
            q_tick[i] = q_tick[i + 1];
        end
        q_len--;
    endfunction

    // update the mirror and queue the answers that this request causes
    function automatic void predict_queue_answers(req_t r);
        answer_t a;
        int n;
        bit hit;
        n = 0;
        case (r.cmd)
            CMD_APPEND:
            begin
                if (q_len >= QUEUE_DEPTH)
                    pending_answers.push_back(status_answer(ST_FULL));
                else
                begin
                    q_id[q_len] = r.id;
                    q_src[q_len] = r.src;
                    q_dst[q_len] = r.dst;
                    q_tick[q_len] = r.tick;
                    q_len++;
                    pending_answers.push_back(status_answer(ST_ADDED));
                end
            end
            CMD_POP:
            begin
                if (is_closed)
                    pending_answers.push_back(status_answer(ST_CLOSED));
                else if (q_len == 0)
                    pending_answers.push_back(status_answer(ST_EMPTY));
                else
                begin
                    a = '{st: ST_ENTRY, id: q_id[0], src: q_src[0], dst: q_dst[0],
                          tick: q_tick[0], cnt: 7'd1, fin: 1'b1};
                    pending_answers.push_back(a);
                    drop_slot(0);
                end
            end
            CMD_EXTRACT:
            begin
                if (r.dir == 2'b00)
                    pending_answers.push_back(status_answer(ST_INVALID));
                else if (is_closed)
                    pending_answers.push_back(status_answer(ST_CLOSED));
                else if (q_len == 0)
                    pending_answers.push_back(status_answer(ST_EMPTY));
                else
                begin
                    for (int i = q_len - 1; i >= 0; i--)
                    begin
                        hit = (q_src[i] == r.floor) &&
                              ((r.dir == 2'b01) ? (q_dst[i] > q_src[i])
                                                : (q_dst[i] < q_src[i]));
                        if (hit)
                        begin
                            n++;
                            a = '{st: ST_ENTRY, id: q_id[i], src: q_src[i], dst: q_dst[i],
                                  tick: q_tick[i], cnt: 7'(n), fin: 1'b0};
                            pending_answers.push_back(a);
                            drop_slot(i);
                        end
                    end
                    if (n == 0)
                        pending_answers.push_back(status_answer(ST_NONE));
                    else
                        pending_answers[pending_answers.size() - 1].fin = 1'b1;
                end
            end
            default:
                pending_answers.push_back(status_answer(ST_INVALID));
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_closed(logic v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= {31'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        is_closed = v;
    endtask

    // one item through the input handshake; typed answer checked against the predictor too
    task automatic send_request(req_t r, logic typed, logic [2:0] st);
        int gap;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= r.cmd;
        person_id <= r.id;
        src_floor <= r.src;
        dst_floor <= r.dst;
        arrive_tick <= r.tick;
        match_floor <= r.floor;
        direction <= r.dir;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_queue_answers(r);
        if (typed && pending_answers[pending_answers.size() - 1].st !== st)
        begin
            n_errors++;
            if (n_errors <= 10)
                $display("typed status mismatch: expected %0d predicted %0d",
                         st, pending_answers[pending_answers.size() - 1].st);
        end
    endtask

    // output side: random stall, compare accepted items
    initial
    begin
        answer_t e;
        int hold;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_answers.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected item: status %0d id %h", status, person_id_res);
            end
            else
            begin
                e = pending_answers.pop_front();
                if (status !== e.st || person_id_res !== e.id || src_floor_res !== e.src ||
                    dst_floor_res !== e.dst || arrive_tick_res !== e.tick ||
                    pick_count !== e.cnt || last !== e.fin)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp st %0d id %h %0d->%0d t %h n %0d l %0b",
                                 e.st, e.id, e.src, e.dst, e.tick, e.cnt, e.fin,
                                 ", got st %0d id %h %0d->%0d t %h n %0d l %0b",
                                 status, person_id_res, src_floor_res, dst_floor_res,
                                 arrive_tick_res, pick_count, last);
                end
            end
        end
    end

    function automatic req_t make_req(logic [1:0] c, logic [31:0] id, logic [7:0] s,
                                      logic [7:0] d, logic [31:0] t, logic [7:0] f,
                                      logic [1:0] dir);
        req_t r;
        r = '{cmd: c, id: id, src: s, dst: d, tick: t, floor: f, dir: dir};
        return r;
    endfunction

    function automatic req_t random_req();
        req_t r;
        int pick;
        logic [7:0] f;
        f = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0)
            f = 8'($urandom);
        r = make_req(CMD_APPEND, $urandom, f, 8'($urandom_range(0, 5)), $urandom,
                     8'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 9) == 0)
            r.dst = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.cmd = CMD_APPEND;
        else if (pick < 68)
            r.cmd = CMD_POP;
        else if (pick < 96)
            r.cmd = CMD_EXTRACT;
        else
            r.cmd = CMD_UNKNOWN;
        if (r.cmd == CMD_EXTRACT && r.dir == 2'b00 && $urandom_range(0, 2) != 0)
            r.dir = 2'b01;
        return r;
    endfunction

    row_t directed[$];

    initial
    begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        cmd = '0;
        person_id = '0;
        src_floor = '0;
        dst_floor = '0;
        arrive_tick = '0;
        match_floor = '0;
        direction = '0;
        rst_n = 1'b0;
        q_len = 0;
        is_closed = 1'b0;
        n_errors = 0;

        directed.push_back('{make_req(CMD_POP, 0, 0, 0, 0, 0, 2'b01), 1'b1, ST_EMPTY});
        directed.push_back('{make_req(CMD_EXTRACT, 0, 0, 0, 0, 0, 2'b01), 1'b1, ST_EMPTY});
        directed.push_back('{make_req(CMD_EXTRACT, 0, 0, 0, 0, 0, 2'b00), 1'b1, ST_INVALID});
        directed.push_back('{make_req(CMD_UNKNOWN, 0, 0, 0, 0, 0, 2'b01), 1'b1, ST_INVALID});
        directed.push_back('{make_req(CMD_APPEND, '1, 8'hff, 8'h00, '1, 0, 0), 1'b1, ST_ADDED});
        directed.push_back('{make_req(CMD_APPEND, 0, 8'h00, 8'hff, 0, 0, 0), 1'b1, ST_ADDED});
        directed.push_back('{make_req(CMD_APPEND, 32'h5, 8'h00, 8'h00, 32'h7, 0, 0), 1'b1,
                             ST_ADDED});
        directed.push_back('{make_req(CMD_APPEND, 32'h6, 8'hff, 8'h10, 32'h8, 0, 0), 1'b1,
                             ST_ADDED});
        directed.push_back('{make_req(CMD_EXTRACT, 0, 0, 0, 0, 8'hff, 2'b10), 1'b0, 0});
        directed.push_back('{make_req(CMD_EXTRACT, 0, 0, 0, 0, 8'h00, 2'b01), 1'b0, 0});
        directed.push_back('{make_req(CMD_EXTRACT, 0, 0, 0, 0, 8'h00, 2'b11), 1'b1, ST_NONE});
        directed.push_back('{make_req(CMD_POP, 0, 0, 0, 0, 0, 0), 1'b0, 0});
        directed.push_back('{make_req(CMD_POP, 0, 0, 0, 0, 0, 0), 1'b1, ST_EMPTY});
        for (int i = 0; i < 17; i++)
            directed.push_back('{make_req(CMD_APPEND, 32'(i), 8'd3, 8'(i % 3 + 2), 32'(i),
                                          0, 0), 1'b1, (i < 16) ? ST_ADDED : ST_FULL});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i].rq, directed[i].typed, directed[i].st);
        wait_drained();
        write_closed(1'b1);
        send_request(make_req(CMD_POP, 0, 0, 0, 0, 0, 0), 1'b1, ST_CLOSED);
        send_request(make_req(CMD_EXTRACT, 0, 0, 0, 0, 8'd3, 2'b01), 1'b1, ST_CLOSED);
        send_request(make_req(CMD_EXTRACT, 0, 0, 0, 0, 8'd3, 2'b00), 1'b1, ST_INVALID);
        wait_drained();
        write_closed(1'b0);
        send_request(make_req(CMD_EXTRACT, 0, 0, 0, 0, 8'd3, 2'b01), 1'b0, 0);
        send_request(make_req(CMD_EXTRACT, 0, 0, 0, 0, 8'd3, 2'b11), 1'b0, 0);

        for (int i = 0; i < 70; i++)
        begin
            if (i == 20 || i == 45)
            begin
                wait_drained();
                write_closed(i == 20);
            end
            if (i == 35)
                wait_drained();
            send_request(random_req(), 1'b0, 0);
        end
        wait_drained();
        if (n_errors == 0)
            $display("ordered_queue_with_match_extract_top regression: pass");
        else
            $display("ordered_queue_with_match_extract_top regression: fail");
        $finish;
    end
endmodule

/* sim.f */
rtl/oqme_pkg.sv
rtl/oqme_ctrl.sv
rtl/oqme_dp.sv
rtl/ordered_queue_with_match_extract_top.sv
test/tb_top.sv
